@@ sv/dllm_pkg.sv @@
package dllm_pkg;

    // Field widths of the request and response items.
    localparam int REQ_W    = 3;
    localparam int DIN_W    = 32;
    localparam int SEL_W    = 4;
    localparam int DOUT_W   = 32;
    localparam int HANDLE_W = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [REQ_W-1:0]    t_req;
    typedef logic [STATUS_W-1:0] t_status;

    // Request kinds.
    localparam t_req REQ_PUSH_TAIL = 3'd0;
    localparam t_req REQ_PUSH_HEAD = 3'd1;
    localparam t_req REQ_POP_TAIL  = 3'd2;
    localparam t_req REQ_POP_HEAD  = 3'd3;
    localparam t_req REQ_REMOVE    = 3'd4;

    // Response status codes.
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_EMPTY   = 2'd1;
    localparam t_status ST_FULL    = 2'd2;
    localparam t_status ST_INVALID = 2'd3;

endpackage

@@ sv/dllm_req_if.sv @@
interface dllm_req_if;
    logic                        valid;
    logic                        ready;
    logic [dllm_pkg::REQ_W-1:0]  req_type;
    logic [dllm_pkg::DIN_W-1:0]  data_in;
    logic [dllm_pkg::SEL_W-1:0]  node_sel;

    modport source (output valid, output req_type, output data_in, output node_sel,
                    input ready);
    modport sink   (input valid, input req_type, input data_in, input node_sel,
                    output ready);
endinterface

@@ sv/dllm_rsp_if.sv @@
interface dllm_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [dllm_pkg::DOUT_W-1:0]    data_out;
    logic [dllm_pkg::HANDLE_W-1:0]  node_handle;
    logic [dllm_pkg::STATUS_W-1:0]  status;
    logic [dllm_pkg::COUNT_W-1:0]   entry_count;

    modport source (output valid, output data_out, output node_handle, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input data_out, input node_handle, input status,
                    input entry_count, output ready);
endinterface

@@ sv/dllm_ram.sv @@
module dllm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/doubly_linked_list_manager_top.sv @@
// Doubly linked list deque over a pool of NODES nodes. Each request item pushes at the
// tail or head (claiming the lowest numbered free node), pops from the tail or head, or
// unlinks the node named by node_sel, and each returns exactly one response item with
// the data word, the node handle, a status and the entry count after the request.
// The block takes one request per cycle unless stalled by back pressure: the first stage
// reads the node's data and links from the node memories at an address formed from
// the head or tail pointer as the previous request leaves it, or from node_sel, and
// the second stage updates the links and loads the response register. Back pressure
// on the response side stalls the request side once the two-stage pipeline is full.
// The node memories need no clearing after reset.
module doubly_linked_list_manager_top #(
    parameter int NODES      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dllm_req_if.sink   i_req,
    dllm_rsp_if.source o_rsp
);

    // Node index width, list count width and a width wide enough to compare a
    // request's node handle against the pool size.
    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);
    localparam int EW = (CW > dllm_pkg::SEL_W) ? CW : dllm_pkg::SEL_W;

    // ------------------------------------------------------------------
    // List state. The links of the end nodes are never followed: whether a
    // node is the head or the tail is decided by comparing with the pointers,
    // so a push only writes the pair of links that join it to the list.
    // ------------------------------------------------------------------
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;
    logic [NODES-1:0] r_in_use, n_in_use;

    // Stage one: the accepted request, its memory reads in flight.
    logic                          r_s1_vld;
    dllm_pkg::t_req                r_s1_req;
    logic [dllm_pkg::DIN_W-1:0]    r_s1_data;
    logic [dllm_pkg::SEL_W-1:0]    r_s1_sel;

    // Forwarding of a write made by the request finishing in the same cycle
    // as the read of the next one.
    logic                  r_byp_next, r_byp_prev, r_byp_data;
    logic [AW-1:0]         r_byp_next_val, r_byp_prev_val;
    logic [DATA_WIDTH-1:0] r_byp_data_val;

    // Response register.
    logic                            r_out_vld;
    logic [dllm_pkg::DOUT_W-1:0]     r_out_data;
    logic [dllm_pkg::HANDLE_W-1:0]   r_out_handle;
    dllm_pkg::t_status               r_out_status;
    logic [dllm_pkg::COUNT_W-1:0]    r_out_count;

    // Handshake.
    logic s1_fire;
    logic in_accept;

    assign s1_fire     = r_s1_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_s1_vld || s1_fire;
    assign in_accept   = i_req.valid && i_req.ready;

    // Memory ports.
    logic                  next_we, prev_we, data_we;
    logic [AW-1:0]         next_waddr, prev_waddr, data_waddr;
    logic [AW-1:0]         next_wdata, prev_wdata;
    logic [DATA_WIDTH-1:0] data_wdata;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         next_q, prev_q;
    logic [DATA_WIDTH-1:0] data_q;

    dllm_ram #(.WIDTH(AW), .DEPTH(NODES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_re    (in_accept),
        .i_raddr (raddr),
        .o_rdata (next_q)
    );

    dllm_ram #(.WIDTH(AW), .DEPTH(NODES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_re    (in_accept),
        .i_raddr (raddr),
        .o_rdata (prev_q)
    );

    dllm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_re    (in_accept),
        .i_raddr (raddr),
        .o_rdata (data_q)
    );

    // ------------------------------------------------------------------
    // Stage two: apply the request in the first stage to the list.
    // ------------------------------------------------------------------
    logic [AW-1:0]                 rd_next, rd_prev;
    logic [DATA_WIDTH-1:0]         rd_data;
    logic                          free_found;
    logic [AW-1:0]                 free_idx;
    logic [EW-1:0]                 s1_sel_ext;
    logic                          s1_sel_ok;
    logic [AW-1:0]                 s1_sel_addr;
    logic [AW-1:0]                 victim;
    logic                          take_ok;
    logic                          is_head, is_tail;
    logic [dllm_pkg::DOUT_W-1:0]   rsp_data;
    logic [dllm_pkg::HANDLE_W-1:0] rsp_handle;
    dllm_pkg::t_status             rsp_status;

    assign rd_next = r_byp_next ? r_byp_next_val : next_q;
    assign rd_prev = r_byp_prev ? r_byp_prev_val : prev_q;
    assign rd_data = r_byp_data ? r_byp_data_val : data_q;

    assign s1_sel_ext  = EW'(r_s1_sel);
    assign s1_sel_ok   = s1_sel_ext < EW'(NODES);
    assign s1_sel_addr = s1_sel_ext[AW-1:0];

    // Lowest numbered free node.
    always_comb begin
        free_idx = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                free_idx = AW'(i);
            end
        end
    end
    assign free_found = ~&r_in_use;

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_in_use   = r_in_use;
        next_we    = 1'b0;
        next_waddr = '0;
        next_wdata = '0;
        prev_we    = 1'b0;
        prev_waddr = '0;
        prev_wdata = '0;
        data_we    = 1'b0;
        data_waddr = free_idx;
        data_wdata = DATA_WIDTH'(r_s1_data);
        victim     = s1_sel_addr;
        take_ok    = 1'b0;
        is_head    = 1'b0;
        is_tail    = 1'b0;
        rsp_data   = '0;
        rsp_handle = '0;
        rsp_status = dllm_pkg::ST_OK;

        case (r_s1_req)
            dllm_pkg::REQ_PUSH_TAIL, dllm_pkg::REQ_PUSH_HEAD: begin
                if (!free_found) begin
                    rsp_status = dllm_pkg::ST_FULL;
                end else begin
                    rsp_handle         = dllm_pkg::HANDLE_W'(free_idx);
                    data_we            = s1_fire;
                    n_in_use[free_idx] = 1'b1;
                    n_count            = r_count + 1'b1;
                    if (r_count == '0) begin
                        n_head = free_idx;
                        n_tail = free_idx;
                    end else if (r_s1_req == dllm_pkg::REQ_PUSH_HEAD) begin
                        next_we    = s1_fire;
                        next_waddr = free_idx;
                        next_wdata = r_head;
                        prev_we    = s1_fire;
                        prev_waddr = r_head;
                        prev_wdata = free_idx;
                        n_head     = free_idx;
                    end else begin
                        prev_we    = s1_fire;
                        prev_waddr = free_idx;
                        prev_wdata = r_tail;
                        next_we    = s1_fire;
                        next_waddr = r_tail;
                        next_wdata = free_idx;
                        n_tail     = free_idx;
                    end
                end
            end
            dllm_pkg::REQ_POP_TAIL, dllm_pkg::REQ_POP_HEAD, dllm_pkg::REQ_REMOVE: begin
                if (r_s1_req == dllm_pkg::REQ_POP_TAIL) begin
                    victim  = r_tail;
                    take_ok = r_count != '0;
                end else if (r_s1_req == dllm_pkg::REQ_POP_HEAD) begin
                    victim  = r_head;
                    take_ok = r_count != '0;
                end else begin
                    victim  = s1_sel_addr;
                    take_ok = s1_sel_ok && r_in_use[s1_sel_addr];
                end
                if (!take_ok) begin
                    rsp_status = (r_s1_req == dllm_pkg::REQ_REMOVE) ?
                                 dllm_pkg::ST_INVALID : dllm_pkg::ST_EMPTY;
                end else begin
                    is_head          = victim == r_head;
                    is_tail          = victim == r_tail;
                    rsp_data         = dllm_pkg::DOUT_W'(rd_data);
                    rsp_handle       = dllm_pkg::HANDLE_W'(victim);
                    n_in_use[victim] = 1'b0;
                    n_count          = r_count - 1'b1;
                    if (is_head) begin
                        n_head = rd_next;
                    end else begin
                        next_we    = s1_fire;
                        next_waddr = rd_prev;
                        next_wdata = rd_next;
                    end
                    if (is_tail) begin
                        n_tail = rd_prev;
                    end else begin
                        prev_we    = s1_fire;
                        prev_waddr = rd_next;
                        prev_wdata = rd_prev;
                    end
                end
            end
            default: begin
                // Unknown request kinds leave the list as it is.
            end
        endcase

        // Nothing changes unless the request actually completes this cycle.
        if (!s1_fire) begin
            n_head   = r_head;
            n_tail   = r_tail;
            n_count  = r_count;
            n_in_use = r_in_use;
        end
    end

    // ------------------------------------------------------------------
    // Stage one read address, formed from the pointers as the request now
    // completing leaves them.
    // ------------------------------------------------------------------
    logic [EW-1:0] in_sel_ext;

    assign in_sel_ext = EW'(i_req.node_sel);

    always_comb begin
        case (i_req.req_type)
            dllm_pkg::REQ_POP_TAIL: raddr = n_tail;
            dllm_pkg::REQ_POP_HEAD: raddr = n_head;
            default:                raddr = in_sel_ext[AW-1:0];
        endcase
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_in_use   <= '0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_byp_next <= 1'b0;
            r_byp_prev <= 1'b0;
            r_byp_data <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_in_use <= n_in_use;

            if (in_accept) begin
                r_s1_vld   <= 1'b1;
                r_byp_next <= next_we && (next_waddr == raddr);
                r_byp_prev <= prev_we && (prev_waddr == raddr);
                r_byp_data <= data_we && (data_waddr == raddr);
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end

            if (s1_fire) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_req       <= i_req.req_type;
            r_s1_data      <= i_req.data_in;
            r_s1_sel       <= i_req.node_sel;
            r_byp_next_val <= next_wdata;
            r_byp_prev_val <= prev_wdata;
            r_byp_data_val <= data_wdata;
        end
        if (s1_fire) begin
            r_out_data   <= rsp_data;
            r_out_handle <= rsp_handle;
            r_out_status <= rsp_status;
            r_out_count  <= dllm_pkg::COUNT_W'(n_count);
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.data_out    = r_out_data;
    assign o_rsp.node_handle = r_out_handle;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_count;

endmodule
